>>> design/sprite_xor_draw_with_collision_top_macros.svh
// Assertion macros for the sprite draw block.
// Used by the top level; no other dependencies.
`ifndef SPRITE_XOR_DRAW_WITH_COLLISION_TOP_MACROS_SVH
`define SPRITE_XOR_DRAW_WITH_COLLISION_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SXD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sprite draw check failed");

// Next-cycle implication, disabled while reset is high.
`define SXD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sprite draw check failed");

`endif

>>> design/sxd_pkg.sv
// Shared constants and types for the sprite draw block.
// No dependencies; imported by every module of the block.
`default_nettype none

package sxd_pkg;

   // Frame geometry; both must be powers of two (wrap and row base use masks).
   localparam int FRAME_WIDTH  = 64;
   localparam int FRAME_HEIGHT = 32;
   localparam int COL_W        = $clog2(FRAME_WIDTH);
   localparam int ROW_W        = $clog2(FRAME_HEIGHT);

   // Field widths of the transactions.
   localparam int KIND_W     = 2;
   localparam int POS_W      = 8;
   localparam int OFFSET_W   = 4;
   localparam int SPRITE_W   = 8;
   localparam int READ_ROW_W = 5;
   localparam int ROW_BITS_W = 64;

   typedef logic [FRAME_WIDTH-1:0] word_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR = 2'd0,
      KIND_DRAW  = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;   // capture request, issue row read
      logic exec;   // modify/write row, load response register
   } cmd_type;

endpackage

`default_nettype wire

>>> design/sxd_ctrl.sv
// Sequencing controller for the sprite draw block.
// Depends on sxd_pkg (cmd_type).
`default_nettype none

module sxd_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output sxd_pkg::cmd_type     cmd
);
   import sxd_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   assign cmd.load = (state_ff == ST_IDLE) && req_valid;
   assign cmd.exec = (state_ff == ST_EXEC) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_EXEC;
               end
               if (rsp_valid_ff && !rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            ST_EXEC: begin
               if (out_free) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> design/sxd_dp.sv
// Datapath: frame memory with row valid bits, mask build, XOR and response registers.
// Depends on sxd_pkg (geometry, field widths, kind codes, cmd_type).
`default_nettype none

module sxd_dp (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire sxd_pkg::cmd_type                cmd,
   input  wire logic [sxd_pkg::KIND_W-1:0]      req_kind,
   input  wire logic [sxd_pkg::POS_W-1:0]       req_pos_x,
   input  wire logic [sxd_pkg::POS_W-1:0]       req_pos_y,
   input  wire logic [sxd_pkg::OFFSET_W-1:0]    req_row_offset,
   input  wire logic [sxd_pkg::SPRITE_W-1:0]    req_sprite_row,
   input  wire logic                            req_last_row,
   input  wire logic [sxd_pkg::READ_ROW_W-1:0]  req_read_row,
   output logic                                 rsp_collision,
   output logic                                 rsp_sprite_done,
   output logic [sxd_pkg::ROW_BITS_W-1:0]       rsp_row_bits
);
   import sxd_pkg::*;

   localparam int ROW_SUM_W = ROW_W + 1;
   localparam int COL_SUM_W = POS_W + 1;

   word_type frame_mem_ff [FRAME_HEIGHT];
   logic [FRAME_HEIGHT-1:0] valid_ff;
   logic                    seen_ff;

   // captured request
   logic [KIND_W-1:0] kind_ff;
   logic [ROW_W-1:0]  addr_ff;
   logic              row_ok_ff;
   logic              first_ff;
   logic              last_ff;
   word_type          mask_ff;
   word_type          rd_data_ff;
   logic              rd_valid_ff;

   // response registers
   logic              collision_ff;
   logic              done_ff;
   word_type          row_bits_ff;

   logic [ROW_SUM_W-1:0] draw_row;
   logic [ROW_W-1:0]     addr_in;
   logic                 row_ok_in;
   word_type             mask_in;
   word_type             old_word;
   word_type             new_word;
   logic                 hit;
   logic                 seen_in;

   // Row of a draw: base row is pos_y mod height (identity when in range).
   assign draw_row = {1'b0, req_pos_y[ROW_W-1:0]} + ROW_SUM_W'(req_row_offset);

   always_comb begin
      if (req_kind == KIND_DRAW) begin
         addr_in   = draw_row[ROW_W-1:0];
         row_ok_in = draw_row < ROW_SUM_W'(FRAME_HEIGHT);
      end else begin
         addr_in   = req_read_row[ROW_W-1:0];
         row_ok_in = {1'b0, req_read_row} < (READ_ROW_W+1)'(FRAME_HEIGHT);
      end
   end

   // Pixel mask: MSB of the sprite byte lands at pos_x.
   always_comb begin
      logic                 wrap;
      logic [COL_SUM_W-1:0] col;
      mask_in = '0;
      wrap    = {1'b0, req_pos_x} >= COL_SUM_W'(FRAME_WIDTH);
      for (int j = 0; j < SPRITE_W; j++) begin
         col = {1'b0, req_pos_x} + COL_SUM_W'(j);
         if (req_sprite_row[3'(SPRITE_W-1-j)]) begin
            if (wrap || (col < COL_SUM_W'(FRAME_WIDTH))) begin
               mask_in[col[COL_W-1:0]] = 1'b1;
            end
         end
      end
   end

   assign old_word = rd_valid_ff ? rd_data_ff : '0;
   assign new_word = old_word ^ mask_ff;
   assign hit      = row_ok_ff && ((old_word & mask_ff) != '0);
   assign seen_in  = (first_ff ? 1'b0 : seen_ff) | hit;

   // Capture stage and registered memory read.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff     <= req_kind;
         addr_ff     <= addr_in;
         row_ok_ff   <= row_ok_in;
         first_ff    <= (req_row_offset == '0);
         last_ff     <= req_last_row;
         mask_ff     <= mask_in;
         rd_data_ff  <= frame_mem_ff[addr_in];
         rd_valid_ff <= valid_ff[addr_in];
      end
   end

   // Memory write port.
   always_ff @(posedge clock) begin
      if (cmd.exec && (kind_ff == KIND_DRAW) && row_ok_ff) begin
         frame_mem_ff[addr_ff] <= new_word;
      end
   end

   // Row valid bits and sprite collision state.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         seen_ff  <= 1'b0;
      end else if (cmd.exec) begin
         if (kind_ff == KIND_CLEAR) begin
            valid_ff <= '0;
         end
         if (kind_ff == KIND_DRAW) begin
            seen_ff <= seen_in;
            if (row_ok_ff) begin
               valid_ff[addr_ff] <= 1'b1;
            end
         end
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         unique case (kind_ff)
            KIND_DRAW: begin
               collision_ff <= seen_in;
               done_ff      <= last_ff;
               row_bits_ff  <= '0;
            end
            KIND_READ: begin
               collision_ff <= 1'b0;
               done_ff      <= 1'b0;
               row_bits_ff  <= row_ok_ff ? old_word : '0;
            end
            default: begin
               collision_ff <= 1'b0;
               done_ff      <= 1'b0;
               row_bits_ff  <= '0;
            end
         endcase
      end
   end

   assign rsp_collision   = collision_ff;
   assign rsp_sprite_done = done_ff;
   assign rsp_row_bits    = ROW_BITS_W'(row_bits_ff);

endmodule

`default_nettype wire

>>> design/sprite_xor_draw_with_collision_top.sv
// Sprite draw block with collision: 64x32 one-bit frame, XOR sprite rows.
// Top level; uses sxd_pkg, sxd_ctrl, sxd_dp and the assertion macro header.
//
// Usage:
//  - Request channel (req_valid/req_stall): one transaction is a frame clear,
//    one sprite row draw (pos_x, pos_y, row_offset, sprite_row, last_row) or
//    one frame row read (read_row).
//  - Response channel (rsp_valid/rsp_stall): exactly one response per request,
//    in order: collision and sprite_done for draws, row_bits for reads, and
//    all zeros for a clear or an unused kind.
//  - An accepted request executes once the response register is free, and
//    its response is registered by that execute step.
//  - A new request is not taken until the previous one has executed; the
//    frame memory's registered read is followed by the row write at execute.
//  - A waiting response does not block the next request: a new request is
//    taken while the response register is still full, and its execute step
//    waits only until that register is drained.
//  - Reset (synchronous): all frame rows read back as zero and the
//    collision flag is clear; per-row valid bits stand in for a clearing pass,
//    so the block is ready the cycle after reset drops. A clear request also
//    finishes in its execute step, by clearing every row valid bit.
//  - A stalled response holds its value until taken.
`default_nettype none
`include "sprite_xor_draw_with_collision_top_macros.svh"

module sprite_xor_draw_with_collision_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [sxd_pkg::KIND_W-1:0]      req_kind,
   input  wire logic [sxd_pkg::POS_W-1:0]       req_pos_x,
   input  wire logic [sxd_pkg::POS_W-1:0]       req_pos_y,
   input  wire logic [sxd_pkg::OFFSET_W-1:0]    req_row_offset,
   input  wire logic [sxd_pkg::SPRITE_W-1:0]    req_sprite_row,
   input  wire logic                            req_last_row,
   input  wire logic [sxd_pkg::READ_ROW_W-1:0]  req_read_row,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_collision,
   output logic                                 rsp_sprite_done,
   output logic [sxd_pkg::ROW_BITS_W-1:0]       rsp_row_bits
);
   import sxd_pkg::*;

   cmd_type cmd;

   // Controller: accept / execute sequencing and response valid.
   sxd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Datapath: frame memory read-modify-write and response payload.
   sxd_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_kind        (req_kind),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_row_offset  (req_row_offset),
      .req_sprite_row  (req_sprite_row),
      .req_last_row    (req_last_row),
      .req_read_row    (req_read_row),
      .rsp_collision   (rsp_collision),
      .rsp_sprite_done (rsp_sprite_done),
      .rsp_row_bits    (rsp_row_bits)
   );

   // One transaction in flight: after an accept, the next request waits.
   `SXD_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall)
   // Capture and execute never coincide.
   `SXD_ASSERT_SAME(a_load_exec_excl, clock, reset, cmd.load, !cmd.exec)
   // Execute always delivers a response in the next cycle.
   `SXD_ASSERT_NEXT(a_exec_responds, clock, reset, cmd.exec, rsp_valid)
   // Responses that carry row bits never report collision or sprite end.
   `SXD_ASSERT_SAME(a_flags_only_draw, clock, reset, rsp_valid && (rsp_row_bits != '0),
                    !rsp_collision && !rsp_sprite_done)

endmodule

`default_nettype wire

>>> tb/tb_sprite_xor_draw_with_collision_top.sv
// Self-checking testbench for the sprite XOR draw block with collision flag.
// Depends on sxd_pkg and sprite_xor_draw_with_collision_top; scoreboarded
// against a frame model kept inside the testbench.
module tb_sprite_xor_draw_with_collision_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sxd_pkg::*;

   // Kind code the block must ignore (all response fields zero, no state change).
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   localparam int unsigned RANDOM_ITEMS   = 700;
   localparam int unsigned HOLD_CYCLES    = 120;   // long receiver hold-off
   localparam int unsigned PRESSURE_ITEMS = 16;    // offered during the hold-off
   localparam int unsigned TAIL_CYCLES    = 8;     // drain margin for any stray response
   localparam int unsigned WATCHDOG_LIMIT = 1000;  // cycles with no transaction at all

   // One request transaction, field for field as on the req_ ports.
   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [POS_W-1:0]      pos_x;
      logic [POS_W-1:0]      pos_y;
      logic [OFFSET_W-1:0]   row_offset;
      logic [SPRITE_W-1:0]   sprite_row;
      logic                  last_row;
      logic [READ_ROW_W-1:0] read_row;
   } draw_req_type;

   // One response transaction.
   typedef struct packed {
      logic                  collision;
      logic                  sprite_done;
      logic [ROW_BITS_W-1:0] row_bits;
   } draw_rsp_type;

   // Directed row: request, plus a hand-written response where it is obvious.
   typedef struct packed {
      draw_req_type req;
      logic         typed;
      draw_rsp_type rsp;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [KIND_W-1:0]     req_kind;
   logic [POS_W-1:0]      req_pos_x;
   logic [POS_W-1:0]      req_pos_y;
   logic [OFFSET_W-1:0]   req_row_offset;
   logic [SPRITE_W-1:0]   req_sprite_row;
   logic                  req_last_row;
   logic [READ_ROW_W-1:0] req_read_row;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_collision;
   logic                  rsp_sprite_done;
   logic [ROW_BITS_W-1:0] rsp_row_bits;

   // Testbench copy of the block state.
   word_type              frame_model [FRAME_HEIGHT];
   logic                  collide_seen;

   // Responses still owed by the block, oldest first.
   draw_rsp_type          pending_rsp_q[$];

   int unsigned           n_errors;
   int unsigned           n_items;
   int unsigned           n_sprites;
   int unsigned           n_hits;        // finished sprites that reported a collision
   int unsigned           n_lit_reads;   // reads that returned a non-empty row
   int unsigned           idle_cycles;

   // Knobs shared between the sender and the receiver.
   bit                    tx_burst;      // sender: no gaps between items
   bit                    rsp_quiet;     // receiver: no stalls
   bit                    hold_off_req;  // receiver: one long stall, then clears it

   sprite_xor_draw_with_collision_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_row_offset  (req_row_offset),
      .req_sprite_row  (req_sprite_row),
      .req_last_row    (req_last_row),
      .req_read_row    (req_read_row),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_collision   (rsp_collision),
      .rsp_sprite_done (rsp_sprite_done),
      .rsp_row_bits    (rsp_row_bits)
   );

   // 10 ns clock.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Directed table. Rows with typed=1 carry a hand-computed response;
   // the rest are scored against the frame model.
   // ------------------------------------------------------------------
   localparam int unsigned DIR_ROWS = 23;
   localparam dir_row_type dir_tab [DIR_ROWS] = '{
      // fresh frame reads back empty, top and bottom row
      '{'{KIND_READ,   8'd0,   8'd0,   4'd0,  8'h00, 1'b0, 5'd0 }, 1'b1, '{1'b0, 1'b0, 64'h0}},
      '{'{KIND_READ,   8'd0,   8'd0,   4'd0,  8'h00, 1'b0, 5'd31}, 1'b1, '{1'b0, 1'b0, 64'h0}},
      // full byte at the origin: no collision, then read it back
      '{'{KIND_DRAW,   8'd0,   8'd0,   4'd0,  8'hFF, 1'b1, 5'd0 }, 1'b1, '{1'b0, 1'b1, 64'h0}},
      '{'{KIND_READ,   8'd0,   8'd0,   4'd0,  8'h00, 1'b0, 5'd0 }, 1'b1, '{1'b0, 1'b0, 64'hFF}},
      // same byte again erases it and collides
      '{'{KIND_DRAW,   8'd0,   8'd0,   4'd0,  8'hFF, 1'b1, 5'd0 }, 1'b1, '{1'b1, 1'b1, 64'h0}},
      '{'{KIND_READ,   8'd0,   8'd0,   4'd0,  8'h00, 1'b0, 5'd0 }, 1'b1, '{1'b0, 1'b0, 64'h0}},
      // right edge clip
      '{'{KIND_DRAW,   8'd60,  8'd5,   4'd0,  8'hFF, 1'b0, 5'd0 }, 1'b0, '{1'b0, 1'b0, 64'h0}},
      '{'{KIND_READ,   8'd0,   8'd0,   4'd0,  8'h00, 1'b0, 5'd5 }, 1'b0, '{1'b0, 1'b0, 64'h0}},
      // column and row wrap together
      '{'{KIND_DRAW,   8'd200, 8'd40,  4'd1,  8'hA5, 1'b0, 5'd0 }, 1'b0, '{1'b0, 1'b0, 64'h0}},
      // bottom clip with all-ones position
      '{'{KIND_DRAW,   8'd255, 8'd255, 4'd15, 8'h81, 1'b1, 5'd0 }, 1'b0, '{1'b0, 1'b0, 64'h0}},
      // last pixel of the frame
      '{'{KIND_DRAW,   8'd63,  8'd31,  4'd0,  8'h80, 1'b1, 5'd0 }, 1'b0, '{1'b0, 1'b0, 64'h0}},
      '{'{KIND_READ,   8'd0,   8'd0,   4'd0,  8'h00, 1'b0, 5'd31}, 1'b0, '{1'b0, 1'b0, 64'h0}},
      '{'{KIND_READ,   8'd0,   8'd0,   4'd0,  8'h00, 1'b0, 5'd9 }, 1'b0, '{1'b0, 1'b0, 64'h0}},
      // in-range start row, offset pushes past the bottom
      '{'{KIND_DRAW,   8'd0,   8'd30,  4'd3,  8'hFF, 1'b1, 5'd0 }, 1'b0, '{1'b0, 1'b0, 64'h0}},
      // unused kind, every field at its top value
      '{'{KIND_UNUSED, 8'hFF,  8'hFF,  4'hF,  8'hFF, 1'b1, 5'h1F}, 1'b1, '{1'b0, 1'b0, 64'h0}},
      // clear, then a previously lit row reads empty
      '{'{KIND_CLEAR,  8'hFF,  8'hFF,  4'hF,  8'hFF, 1'b1, 5'h1F}, 1'b1, '{1'b0, 1'b0, 64'h0}},
      '{'{KIND_READ,   8'd0,   8'd0,   4'd0,  8'h00, 1'b0, 5'd9 }, 1'b1, '{1'b0, 1'b0, 64'h0}},
      // x=64/y=32 wrap onto the origin of an empty frame
      '{'{KIND_DRAW,   8'd64,  8'd32,  4'd0,  8'hF0, 1'b0, 5'd0 }, 1'b1, '{1'b0, 1'b0, 64'h0}},
      // restart at offset 0 and collide
      '{'{KIND_DRAW,   8'd0,   8'd0,   4'd0,  8'hC0, 1'b1, 5'd0 }, 1'b1, '{1'b1, 1'b1, 64'h0}},
      // flag carries past the last_row mark into offset 1
      '{'{KIND_DRAW,   8'd0,   8'd0,   4'd1,  8'h01, 1'b1, 5'd0 }, 1'b1, '{1'b1, 1'b1, 64'h0}},
      // offset 0 restarts the flag
      '{'{KIND_DRAW,   8'd8,   8'd1,   4'd0,  8'h01, 1'b1, 5'd0 }, 1'b0, '{1'b0, 1'b0, 64'h0}},
      '{'{KIND_READ,   8'd0,   8'd0,   4'd0,  8'h00, 1'b0, 5'd0 }, 1'b0, '{1'b0, 1'b0, 64'h0}},
      '{'{KIND_READ,   8'd0,   8'd0,   4'd0,  8'h00, 1'b0, 5'd1 }, 1'b0, '{1'b0, 1'b0, 64'h0}}
   };

   // ------------------------------------------------------------------
   // Frame model: applies one request to the testbench state and returns
   // the response the block owes for it.
   // ------------------------------------------------------------------
   function automatic draw_rsp_type apply_request(input draw_req_type r);
      draw_rsp_type o;
      word_type     mask;
      int unsigned  row;
      int unsigned  col;
      int unsigned  j;
      int unsigned  i;
      o    = '0;
      mask = '0;
      case (r.kind)
         KIND_CLEAR: begin
            for (i = 0; i < FRAME_HEIGHT; i++) frame_model[i] = '0;
         end
         KIND_DRAW: begin
            if (r.row_offset == '0) collide_seen = 1'b0;
            // Wrapped start row is reduced first, then the offset is added.
            if (int'(r.pos_y) >= FRAME_HEIGHT)
               row = (int'(r.pos_y) % FRAME_HEIGHT) + int'(r.row_offset);
            else
               row = int'(r.pos_y) + int'(r.row_offset);
            if (row < FRAME_HEIGHT) begin
               for (j = 0; j < SPRITE_W; j++) begin
                  if (r.sprite_row[SPRITE_W-1-j]) begin
                     col = int'(r.pos_x) + j;
                     // wrap only when the start column is off the frame
                     if (int'(r.pos_x) >= FRAME_WIDTH) col = col % FRAME_WIDTH;
                     if (col < FRAME_WIDTH) mask[col] = 1'b1;
                  end
               end
               if ((frame_model[row] & mask) != '0) collide_seen = 1'b1;
               frame_model[row] = frame_model[row] ^ mask;
            end
            o.collision   = collide_seen;
            o.sprite_done = r.last_row;
         end
         KIND_READ: begin
            if (int'(r.read_row) < FRAME_HEIGHT) o.row_bits = frame_model[r.read_row];
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic draw_req_type random_req();
      draw_req_type r;
      r.kind       = KIND_W'($urandom_range(0, 3));
      r.pos_x      = POS_W'($urandom);
      r.pos_y      = POS_W'($urandom);
      r.row_offset = OFFSET_W'($urandom);
      r.sprite_row = SPRITE_W'($urandom);
      r.last_row   = 1'($urandom);
      r.read_row   = READ_ROW_W'($urandom);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %-12s got %h expected %h at %0t", what, got, want, $realtime);
      n_errors++;
   endtask

   // Offer one request, hold it until accepted, then log what it owes.
   task automatic send_req(input draw_req_type r, input bit typed,
                           input draw_rsp_type typed_rsp);
      int unsigned  gap;
      draw_rsp_type owed;
      gap = tx_burst ? 0 : $urandom_range(0, 4);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_kind       <= r.kind;
      req_pos_x      <= r.pos_x;
      req_pos_y      <= r.pos_y;
      req_row_offset <= r.row_offset;
      req_sprite_row <= r.sprite_row;
      req_last_row   <= r.last_row;
      req_read_row   <= r.read_row;
      req_valid      <= 1'b1;
      do @(posedge clock); while (req_stall);
      // Model always advances; hand-written rows override the owed response.
      owed = apply_request(r);
      if (typed) owed = typed_rsp;
      pending_rsp_q.push_back(owed);
      n_items++;
   endtask

   // Sender goes quiet until every owed response has been taken.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_rsp_q.size() == 0);
   endtask

   // One well-formed sprite: rows 0..n-1 at a shared position, last row marked.
   task automatic send_sprite();
      draw_req_type r;
      int unsigned  rows;
      int unsigned  x;
      int unsigned  y;
      int unsigned  k;
      rows = $urandom_range(1, 15);
      if ($urandom_range(0, 1) == 0) begin
         // small pool of positions so sprites overlap and collide often
         x = 8 * $urandom_range(0, 7) + 4 * $urandom_range(0, 1);
         y = 4 * $urandom_range(0, 7);
      end else begin
         x = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 63) : $urandom_range(64, 255);
         y = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 31) : $urandom_range(32, 255);
      end
      for (k = 0; k < rows; k++) begin
         r            = random_req();
         r.kind       = KIND_DRAW;
         r.pos_x      = POS_W'(x);
         r.pos_y      = POS_W'(y);
         r.row_offset = OFFSET_W'(k);
         r.last_row   = (k == rows - 1);
         send_req(r, 1'b0, '0);
      end
      n_sprites++;
   endtask

   // ------------------------------------------------------------------
   // Receiver: random stall per response, quiet stretches, and one long
   // hold-off on request. Stall changes only at the falling edge.
   // ------------------------------------------------------------------
   initial begin : rsp_side
      int unsigned stall_n;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end
         stall_n = rsp_quiet ? 0 : $urandom_range(0, 4);
         if (stall_n != 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall) || reset);
      end
   end

   // ------------------------------------------------------------------
   // Response checker and watchdog, sampled on the rising edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      draw_rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp_q.size() == 0) begin
               report_mismatch("unexpected", rsp_row_bits, '0);
            end else begin
               want = pending_rsp_q.pop_front();
               if (rsp_collision !== want.collision)
                  report_mismatch("collision", 64'(rsp_collision), 64'(want.collision));
               if (rsp_sprite_done !== want.sprite_done)
                  report_mismatch("sprite_done", 64'(rsp_sprite_done), 64'(want.sprite_done));
               if (rsp_row_bits !== want.row_bits)
                  report_mismatch("row_bits", rsp_row_bits, want.row_bits);
               if (want.sprite_done && want.collision) n_hits++;
               if (want.row_bits != '0) n_lit_reads++;
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d responses owed",
                     idle_cycles, pending_rsp_q.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence: reset, directed table, random traffic with one
   // back-pressure episode, drain, verdict.
   // ------------------------------------------------------------------
   initial begin : stimulus
      int unsigned  k;
      int unsigned  pick;
      bit           pressure_done;
      draw_req_type r;

      // every block input known from time zero
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_kind       = KIND_CLEAR;
      req_pos_x      = '0;
      req_pos_y      = '0;
      req_row_offset = '0;
      req_sprite_row = '0;
      req_last_row   = 1'b0;
      req_read_row   = '0;
      rsp_stall      = 1'b0;
      tx_burst       = 1'b0;
      rsp_quiet      = 1'b0;
      hold_off_req   = 1'b0;
      pressure_done  = 1'b0;
      collide_seen   = 1'b0;
      n_errors       = 0;
      n_items        = 0;
      n_sprites      = 0;
      n_hits         = 0;
      n_lit_reads    = 0;
      idle_cycles    = 0;
      for (k = 0; k < FRAME_HEIGHT; k++) frame_model[k] = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part
      for (k = 0; k < DIR_ROWS; k++)
         send_req(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].rsp);
      // sender pause: let every owed response come back
      wait_drained();

      // Random part
      while (n_items < DIR_ROWS + RANDOM_ITEMS) begin
         tx_burst  = ($urandom_range(0, 5) == 0);
         rsp_quiet = ($urandom_range(0, 5) == 0);

         // Halfway through: receiver holds off while the sender keeps
         // offering back to back, so the block fills and stalls req_.
         if (!pressure_done && n_items >= DIR_ROWS + RANDOM_ITEMS / 2) begin
            pressure_done = 1'b1;
            wait_drained();
            hold_off_req = 1'b1;
            tx_burst     = 1'b1;
            for (k = 0; k < PRESSURE_ITEMS; k++) begin
               r = random_req();
               if (r.kind == KIND_UNUSED) r.kind = KIND_DRAW;
               send_req(r, 1'b0, '0);
            end
            tx_burst = 1'b0;
            wait_drained();
         end

         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            send_sprite();
         end else begin
            r = random_req();
            if (pick < 75)      r.kind = KIND_READ;
            else if (pick < 79) r.kind = KIND_CLEAR;
            else if (pick < 84) r.kind = KIND_UNUSED;
            else                r.kind = KIND_DRAW;   // stray row, any offset/mark
            send_req(r, 1'b0, '0);
         end
      end

      // Drain and let any stray response show up.
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d requests: %0d directed rows, %0d random sprites.",
               n_items, DIR_ROWS, n_sprites);
      $display("%0d sprites ended with a collision, %0d reads returned lit pixels.",
               n_hits, n_lit_reads);
      if (n_errors == 0 && pending_rsp_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d responses still owed", n_errors, pending_rsp_q.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
